// File: sv/spr_pkg.sv
`default_nettype none

package spr_pkg;

   // Field widths
   localparam int FB_W    = 10;
   localparam int DELAY_W = 16;
   localparam int SCALE_W = 7;
   localparam int DUTY_W  = 8;
   localparam int SINE_W  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FB_HIGH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_LOW       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_DELAY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MAX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_STEP   = 3'd5;

   // Register reset values
   localparam logic [FB_W-1:0]    RST_FB_HIGH      = 10'd120;
   localparam logic [FB_W-1:0]    RST_FB_LOW       = 10'd115;
   localparam logic [DELAY_W-1:0] RST_ENABLE_DELAY = 16'd2000;
   localparam logic [SCALE_W-1:0] RST_SCALE_MIN    = 7'd10;
   localparam logic [SCALE_W-1:0] RST_SCALE_MAX    = 7'd100;
   localparam logic [SCALE_W-1:0] RST_SCALE_STEP   = 7'd1;

   // Half-sine table
   localparam int SINE_LEN   = 32;
   localparam int SINE_IDX_W = 5;

   localparam logic [SINE_W-1:0] SINE_TAB [SINE_LEN] = '{
      8'd0,   8'd25,  8'd49,  8'd73,  8'd96,  8'd118, 8'd139, 8'd159,
      8'd177, 8'd193, 8'd208, 8'd220, 8'd231, 8'd239, 8'd245, 8'd249,
      8'd250, 8'd249, 8'd245, 8'd239, 8'd231, 8'd220, 8'd208, 8'd193,
      8'd177, 8'd159, 8'd139, 8'd118, 8'd96,  8'd73,  8'd49,  8'd25
   };

   // Duty product and divide by 100 as multiply by 5243 / 2^19
   // (exact floor for products below 43690)
   localparam int PROD_W   = SINE_W + SCALE_W;
   localparam int RECIP_W  = 13;
   localparam int RECIP_SH = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int QUOT_W   = 9;
   localparam logic [QUOT_W-1:0] DUTY_MAX = 9'd250;

   // Scale regulation settings
   typedef struct packed {
      logic [FB_W-1:0]    fb_high;
      logic [FB_W-1:0]    fb_low;
      logic [SCALE_W-1:0] scale_min;
      logic [SCALE_W-1:0] scale_max;
      logic [SCALE_W-1:0] scale_step;
   } scale_cfg_type;

endpackage

`default_nettype wire

// File: sv/sine_pwm_inverter_regulator.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   fb_sample, run_pin
// rsp      out        rsp_valid/rsp_stall   duty_a, duty_b, low_side_a, low_side_b
// csr      in         csr_wr_en             csr_index, csr_wdata
//
// One tick per cycle while req is not stalled. A req transfer loads the product
// stage; the divide-by-100 stage then loads the output register when that register
// is empty or rsp is not stalled, which raises rsp_valid.
// Tick state (phase, half, enable count, scale) updates at the req transfer.
// Synchronous active-high reset clears state and restores register defaults.
// A stall on rsp holds the output; req stalls only while both stages hold data
// and rsp is stalled.

module sine_pwm_inverter_regulator
   import spr_pkg::*;
#(
   parameter int TABLE_STEPS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [FB_W-1:0]       req_fb_sample,
   input  wire logic                  req_run_pin,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DUTY_W-1:0]     rsp_duty_a,
   output logic      [DUTY_W-1:0]     rsp_duty_b,
   output logic                       rsp_low_side_a,
   output logic                       rsp_low_side_b,

   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PHASE_W = $clog2(TABLE_STEPS);

   // Configuration registers
   scale_cfg_type        cfg_ff, cfg_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;

   always_comb begin
      cfg_in   = cfg_ff;
      delay_in = delay_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FB_HIGH:      cfg_in.fb_high    = csr_wdata[FB_W-1:0];
            CSR_FB_LOW:       cfg_in.fb_low     = csr_wdata[FB_W-1:0];
            CSR_ENABLE_DELAY: delay_in          = csr_wdata[DELAY_W-1:0];
            CSR_SCALE_MIN:    cfg_in.scale_min  = csr_wdata[SCALE_W-1:0];
            CSR_SCALE_MAX:    cfg_in.scale_max  = csr_wdata[SCALE_W-1:0];
            CSR_SCALE_STEP:   cfg_in.scale_step = csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_high    <= RST_FB_HIGH;
         cfg_ff.fb_low     <= RST_FB_LOW;
         cfg_ff.scale_min  <= RST_SCALE_MIN;
         cfg_ff.scale_max  <= RST_SCALE_MAX;
         cfg_ff.scale_step <= RST_SCALE_STEP;
         delay_ff          <= RST_ENABLE_DELAY;
      end else begin
         cfg_ff   <= cfg_in;
         delay_ff <= delay_in;
      end
   end

   // Pipeline flow control
   logic p1_valid_ff, p1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_adv;
   logic s1_adv;
   logic req_xfer;

   assign s2_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !p1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;
   assign req_xfer  = req_valid && s1_adv;

   // Phase step map: table index for each phase, fixed at elaboration
   logic [SINE_IDX_W-1:0] step_map [TABLE_STEPS];

   for (genvar p = 0; p < TABLE_STEPS; p++) begin : g_map
      localparam int MAP_IDX = (p * SINE_LEN) / TABLE_STEPS;
      assign step_map[p] = SINE_IDX_W'((MAP_IDX > SINE_LEN - 1) ? SINE_LEN - 1 : MAP_IDX);
   end

   // Tick state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               half_ff, half_in;
   logic [DELAY_W-1:0] count_ff, count_in;
   logic               running_ff, running_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SCALE_W-1:0] scale_upd;
   logic [PHASE_W:0]   phase_inc;
   logic               phase_wrap;

   assign phase_inc  = {1'b0, phase_ff} + (PHASE_W+1)'(1);
   assign phase_wrap = (phase_inc == (PHASE_W+1)'(TABLE_STEPS));

   spr_scale_upd u_scale (
      .cfg       (cfg_ff),
      .fb_sample (req_fb_sample),
      .scale_cur (scale_ff),
      .scale_new (scale_upd)
   );

   always_comb begin
      phase_in   = phase_ff;
      half_in    = half_ff;
      count_in   = count_ff;
      running_in = running_ff;
      scale_in   = scale_ff;
      if (req_xfer) begin
         // phase walk, flip half on wrap
         if (phase_wrap) begin
            phase_in = '0;
            half_in  = !half_ff;
         end else begin
            phase_in = phase_inc[PHASE_W-1:0];
         end
         // run pin, active low, with saturating qualify count
         if (!req_run_pin) begin
            if (count_ff != {DELAY_W{1'b1}}) begin
               count_in = count_ff + DELAY_W'(1);
            end
            if (count_in >= delay_ff) begin
               running_in = 1'b1;
            end
         end else begin
            count_in   = '0;
            running_in = 1'b0;
         end
         if (running_in) begin
            scale_in = scale_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         half_ff    <= 1'b0;
         count_ff   <= '0;
         running_ff <= 1'b0;
         scale_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         half_ff    <= half_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         scale_ff   <= scale_in;
      end
   end

   // Stage 1: table value times old scale
   logic [SINE_W-1:0] sine_val;
   logic [PROD_W-1:0] p1_prod_ff, p1_prod_in;
   logic              p1_lsa_ff, p1_lsa_in;
   logic              p1_lsb_ff, p1_lsb_in;

   assign sine_val = SINE_TAB[step_map[phase_in]];

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (s1_adv) begin
         p1_valid_in = req_valid;
      end
      p1_prod_in = running_in ? PROD_W'(sine_val * scale_ff) : '0;
      p1_lsa_in  = running_in && half_in;
      p1_lsb_in  = running_in && !half_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         p1_prod_ff <= p1_prod_in;
         p1_lsa_ff  <= p1_lsa_in;
         p1_lsb_ff  <= p1_lsb_in;
      end
   end

   // Stage 2: divide by 100, saturate, route to the active leg
   logic [PROD_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]         quot;
   logic [DUTY_W-1:0]         duty;
   logic [DUTY_W-1:0]         duty_a_ff, duty_a_in;
   logic [DUTY_W-1:0]         duty_b_ff, duty_b_in;
   logic                      lsa_ff, lsb_ff;

   assign recip_prod = p1_prod_ff * RECIP_100;
   assign quot       = recip_prod[RECIP_SH +: QUOT_W];
   assign duty       = (quot > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : quot[DUTY_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = p1_valid_ff;
      end
      duty_a_in = p1_lsb_ff ? duty : '0;
      duty_b_in = p1_lsa_ff ? duty : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && p1_valid_ff) begin
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
         lsa_ff    <= p1_lsa_ff;
         lsb_ff    <= p1_lsb_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_a     = duty_a_ff;
   assign rsp_duty_b     = duty_b_ff;
   assign rsp_low_side_a = lsa_ff;
   assign rsp_low_side_b = lsb_ff;

endmodule

`default_nettype wire

// File: sv/spr_scale_upd.sv
`default_nettype none

module spr_scale_upd
   import spr_pkg::*;
(
   input  wire scale_cfg_type             cfg,
   input  wire logic [FB_W-1:0]           fb_sample,
   input  wire logic [SCALE_W-1:0]        scale_cur,
   output logic      [SCALE_W-1:0]        scale_new
);

   localparam int SUM_W = SCALE_W + 2;

   logic signed [SUM_W-1:0] stepped;
   logic signed [SUM_W-1:0] lo_lim;
   logic signed [SUM_W-1:0] hi_lim;

   // Step down above the high threshold, up below the low threshold
   always_comb begin
      lo_lim = $signed({2'b00, cfg.scale_min});
      hi_lim = $signed({2'b00, cfg.scale_max});
      priority if (fb_sample > cfg.fb_high) begin
         stepped = $signed({2'b00, scale_cur}) - $signed({2'b00, cfg.scale_step});
      end else if (fb_sample < cfg.fb_low) begin
         stepped = $signed({2'b00, scale_cur}) + $signed({2'b00, cfg.scale_step});
      end else begin
         stepped = $signed({2'b00, scale_cur});
      end
   end

   // Clamp, minimum first
   always_comb begin
      priority if (stepped <= lo_lim) begin
         scale_new = cfg.scale_min;
      end else if (stepped >= hi_lim) begin
         scale_new = cfg.scale_max;
      end else begin
         scale_new = stepped[SCALE_W-1:0];
      end
   end

endmodule

`default_nettype wire
